>>> src/cbpe_pkg.sv
package cbpe_pkg;

  // Field and register widths.
  localparam int COORD_W      = 16;
  localparam int NUM_AXES     = 3;
  localparam int NUM_PTS      = 4;
  localparam int PACK_W       = NUM_AXES * COORD_W;
  localparam int IDX_W        = 10;
  localparam int SEG_W        = 11;
  localparam int MAX_SEGMENTS = 1024;

  // Curve parameter t is unsigned Q0.16 on 17 bits, so that t = 1 is representable.
  localparam int T_FRAC     = 16;
  localparam int T_W        = T_FRAC + 1;
  localparam int REM_W      = SEG_W + 1;
  localparam int DIV_STAGES = T_W;

  // Basis arithmetic widths.
  localparam int SQ_W    = 2 * T_W - 1;
  localparam int CUBE_W  = SQ_W + T_W;
  localparam int W_W     = 2 * T_FRAC + 1;
  localparam int WPROD_W = W_W + 1 + COORD_W;
  localparam int ACC_W   = WPROD_W + 2;

  // Stream and configuration port widths.
  localparam int IN_TDATA_W  = ((IDX_W + 7) / 8) * 8;
  localparam int OUT_FIELD_W = NUM_AXES * COORD_W + 1;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = PACK_W;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_START_POINT    = 3'd0,
    REG_FIRST_CONTROL  = 3'd1,
    REG_SECOND_CONTROL = 3'd2,
    REG_END_POINT      = 3'd3,
    REG_NUM_SEGMENTS   = 3'd4
  } cbpe_reg_t;

  // Reset values: P0 = (-0.5,-0.5,0.5), P1 = (-0.3,0,0), P2 = (0.3,0.2,-0.1),
  // P3 = (0.5,0.5,-0.5) in Q2.14, and 100 segments.
  localparam logic [PACK_W-1:0] START_POINT_RST    = 48'd35188130242560;
  localparam logic [PACK_W-1:0] FIRST_CONTROL_RST  = 48'd60621;
  localparam logic [PACK_W-1:0] SECOND_CONTROL_RST = 48'd274440035046195;
  localparam logic [PACK_W-1:0] END_POINT_RST      = 48'd246291141500928;
  localparam logic [SEG_W-1:0]  NUM_SEGMENTS_RST   = 11'd100;

  typedef struct packed {
    logic valid;
    logic bad;
  } cbpe_tag_t;

  typedef logic [NUM_PTS-1:0][PACK_W-1:0] cbpe_pts_t;
  typedef logic [NUM_PTS-1:0][W_W-1:0]    cbpe_wts_t;
  typedef logic [NUM_AXES-1:0][COORD_W-1:0] cbpe_point_t;

endpackage

>>> src/cbpe_div.sv
module cbpe_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cbpe_pkg::cbpe_tag_t          up_tag,
  input  logic [cbpe_pkg::IDX_W-1:0]   up_index,
  output logic                         up_ready,
  input  logic [cbpe_pkg::SEG_W-1:0]   num_seg,
  output cbpe_pkg::cbpe_tag_t          dn_tag,
  output logic [cbpe_pkg::T_W-1:0]     dn_t,
  input  logic                         dn_ready
);
  import cbpe_pkg::*;

  localparam int S = DIV_STAGES;

  logic [S-1:0]     v_r;
  logic [S-1:0]     bad_r;
  logic [REM_W-1:0] rem_r [S];
  logic [T_W-1:0]   q_r   [S];

  logic [S:0]       rdy;
  logic [REM_W-1:0] src     [S];
  logic [REM_W-1:0] rem_nxt [S];
  logic [T_W-1:0]   q_nxt   [S];
  logic [S-1:0]     ge;
  logic [SEG_W-1:0] idx_inc;
  logic [REM_W-1:0] div_n;
  logic             bad_in;

  // A stage takes a new request when it is empty or its content moves on.
  always_comb begin
    rdy[S] = dn_ready;
    for (int k = S - 1; k >= 0; k--) begin
      rdy[k] = ~v_r[k] | rdy[k + 1];
    end
  end

  // Long division of (i+1) * 2^16 by N, one quotient bit per stage, MSB first.
  always_comb begin
    idx_inc = {1'b0, up_index} + SEG_W'(1);
    bad_in  = (num_seg == '0) || ({1'b0, up_index} >= num_seg);
    div_n   = {1'b0, num_seg};
    src[0]  = {1'b0, idx_inc};
    for (int k = 1; k < S; k++) begin
      src[k] = {rem_r[k - 1][REM_W-2:0], 1'b0};
    end
    for (int k = 0; k < S; k++) begin
      ge[k]      = src[k] >= div_n;
      rem_nxt[k] = ge[k] ? (src[k] - div_n) : src[k];
    end
    q_nxt[0]        = '0;
    q_nxt[0][T_W-1] = ge[0];
    for (int k = 1; k < S; k++) begin
      q_nxt[k]            = q_r[k - 1];
      q_nxt[k][T_W-1-k]   = ge[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= up_tag.valid;
      end
      for (int k = 1; k < S; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k - 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      bad_r[0] <= bad_in;
      rem_r[0] <= rem_nxt[0];
      q_r[0]   <= q_nxt[0];
    end
    for (int k = 1; k < S; k++) begin
      if (rdy[k]) begin
        bad_r[k] <= bad_r[k - 1];
        rem_r[k] <= rem_nxt[k];
        q_r[k]   <= q_nxt[k];
      end
    end
  end

  assign up_ready     = rdy[0];
  assign dn_tag.valid = v_r[S-1];
  assign dn_tag.bad   = bad_r[S-1];
  assign dn_t         = q_r[S-1];

endmodule

>>> src/cbpe_basis.sv
module cbpe_basis (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cbpe_pkg::cbpe_tag_t        up_tag,
  input  logic [cbpe_pkg::T_W-1:0]   up_t,
  output logic                       up_ready,
  output cbpe_pkg::cbpe_tag_t        dn_tag,
  output cbpe_pkg::cbpe_wts_t        dn_w,
  input  logic                       dn_ready
);
  import cbpe_pkg::*;

  localparam int S = 3;
  localparam logic [T_W-1:0]    T_ONE = T_W'(1) << T_FRAC;
  localparam logic [CUBE_W+1:0] HALF  = (CUBE_W + 2)'(1) << (T_FRAC - 1);

  logic [S-1:0]      v_r;
  logic [S-1:0]      bad_r;
  logic [S:0]        rdy;

  logic [T_W-1:0]    t_r, u_r;
  logic [SQ_W-1:0]   t2_r, u2_r;
  logic [CUBE_W-1:0] u3_r, u2t_r, t2u_r, t3_r;
  cbpe_wts_t         w_r;

  logic [T_W-1:0]    u_nxt;
  logic [2*T_W-1:0]  t_sq, u_sq;
  logic [CUBE_W-1:0] u3_nxt, u2t_nxt, t2u_nxt, t3_nxt;
  logic [CUBE_W+1:0] w0_sum, w1_sum, w2_sum, w3_sum;

  always_comb begin
    rdy[S] = dn_ready;
    for (int k = S - 1; k >= 0; k--) begin
      rdy[k] = ~v_r[k] | rdy[k + 1];
    end
  end

  always_comb begin
    u_nxt   = T_ONE - up_t;
    t_sq    = up_t * up_t;
    u_sq    = u_nxt * u_nxt;
    u3_nxt  = u2_r * u_r;
    u2t_nxt = u2_r * t_r;
    t2u_nxt = t2_r * u_r;
    t3_nxt  = t2_r * t_r;
    // Weights in Q0.48 rounded to Q0.32; the factor of three is a shift and add.
    w0_sum  = {2'b00, u3_r} + HALF;
    w1_sum  = {1'b0, u2t_r, 1'b0} + {2'b00, u2t_r} + HALF;
    w2_sum  = {1'b0, t2u_r, 1'b0} + {2'b00, t2u_r} + HALF;
    w3_sum  = {2'b00, t3_r} + HALF;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= up_tag.valid;
      end
      for (int k = 1; k < S; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k - 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      bad_r[0] <= up_tag.bad;
      t_r      <= up_t;
      u_r      <= u_nxt;
      t2_r     <= t_sq[SQ_W-1:0];
      u2_r     <= u_sq[SQ_W-1:0];
    end
    if (rdy[1]) begin
      bad_r[1] <= bad_r[0];
      u3_r     <= u3_nxt;
      u2t_r    <= u2t_nxt;
      t2u_r    <= t2u_nxt;
      t3_r     <= t3_nxt;
    end
    if (rdy[2]) begin
      bad_r[2] <= bad_r[1];
      w_r[0]   <= w0_sum[T_FRAC +: W_W];
      w_r[1]   <= w1_sum[T_FRAC +: W_W];
      w_r[2]   <= w2_sum[T_FRAC +: W_W];
      w_r[3]   <= w3_sum[T_FRAC +: W_W];
    end
  end

  assign up_ready     = rdy[0];
  assign dn_tag.valid = v_r[S-1];
  assign dn_tag.bad   = bad_r[S-1];
  assign dn_w         = w_r;

endmodule

>>> src/cbpe_blend.sv
module cbpe_blend (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cbpe_pkg::cbpe_tag_t    up_tag,
  input  cbpe_pkg::cbpe_wts_t    up_w,
  output logic                   up_ready,
  input  cbpe_pkg::cbpe_pts_t    pts,
  output logic                   dn_valid,
  output logic                   dn_bad,
  output cbpe_pkg::cbpe_point_t  dn_point,
  input  logic                   dn_ready
);
  import cbpe_pkg::*;

  localparam int S    = 3;
  localparam int RW   = ACC_W - 2 * T_FRAC;
  localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(1) << (2 * T_FRAC - 1);
  localparam logic [COORD_W-1:0] SAT_MAX = {1'b0, {(COORD_W - 1){1'b1}}};
  localparam logic [COORD_W-1:0] SAT_MIN = {1'b1, {(COORD_W - 1){1'b0}}};

  logic [S-1:0] v_r;
  logic [S-2:0] bad_r;
  logic         out_bad_r;
  logic [S:0]   rdy;

  logic signed [WPROD_W-1:0] prod_r [NUM_AXES][NUM_PTS];
  logic signed [ACC_W-1:0]   acc_r  [NUM_AXES];
  cbpe_point_t               point_r;

  logic signed [WPROD_W-1:0] prod_nxt [NUM_AXES][NUM_PTS];
  logic signed [ACC_W-1:0]   acc_nxt  [NUM_AXES];
  logic signed [ACC_W-1:0]   biased   [NUM_AXES];
  logic        [RW-1:0]      rnd      [NUM_AXES];
  cbpe_point_t               point_nxt;

  always_comb begin
    rdy[S] = dn_ready;
    for (int k = S - 1; k >= 0; k--) begin
      rdy[k] = ~v_r[k] | rdy[k + 1];
    end
  end

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      for (int p = 0; p < NUM_PTS; p++) begin
        prod_nxt[a][p] = $signed({1'b0, up_w[p]}) * $signed(pts[p][a*COORD_W +: COORD_W]);
      end
      acc_nxt[a] = ACC_W'(prod_r[a][0]) + ACC_W'(prod_r[a][1])
                 + ACC_W'(prod_r[a][2]) + ACC_W'(prod_r[a][3]);
      // Round half up from Q2.46 to Q2.14, then clip to the coordinate range.
      biased[a] = acc_r[a] + RND_BIAS;
      rnd[a]    = biased[a][ACC_W-1:2*T_FRAC];
      if (~rnd[a][RW-1] && (|rnd[a][RW-2:COORD_W-1])) begin
        point_nxt[a] = SAT_MAX;
      end else if (rnd[a][RW-1] && ~(&rnd[a][RW-2:COORD_W-1])) begin
        point_nxt[a] = SAT_MIN;
      end else begin
        point_nxt[a] = rnd[a][COORD_W-1:0];
      end
      if (bad_r[1]) begin
        point_nxt[a] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= up_tag.valid;
      end
      for (int k = 1; k < S; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k - 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      bad_r[0] <= up_tag.bad;
      prod_r   <= prod_nxt;
    end
    if (rdy[1]) begin
      bad_r[1] <= bad_r[0];
      acc_r    <= acc_nxt;
    end
    if (rdy[2]) begin
      out_bad_r <= bad_r[1];
      point_r   <= point_nxt;
    end
  end

  assign up_ready = rdy[0];
  assign dn_valid = v_r[S-1];
  assign dn_bad   = out_bad_r;
  assign dn_point = point_r;

endmodule

>>> src/cubic_bezier_point_eval_unit.sv
// Channel   Direction  Payload
// in_       slave      tdata[9:0] segment_index
// out_      master     tdata[15:0] x, [31:16] y, [47:32] z, [48] index_bad
// cfg_      write      cfg_addr selects the register, cfg_wdata[47:0] the value
//
// One point per clock is accepted and delivered while out_tready is high; a request passes 23 register
// stages on its way to the output register: 17 divider stages (one quotient bit each),
// 3 basis weight stages and 3 blend stages (products, sums, rounding).
// Reset (rst_n low, synchronous) empties every stage and loads the default curve.
// Every stage holds its contents while the one after it is full and stalled, so in_tready
// stays high as long as some stage in the pipeline has room or out_tready is high.
module cubic_bezier_point_eval_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [cbpe_pkg::IN_TDATA_W-1:0]    in_tdata,   // [9:0] segment_index
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [15:0] point_x, [31:16] point_y, [47:32] point_z, [48] index_bad
  output logic [cbpe_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                               cfg_we,
  input  logic [cbpe_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [cbpe_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import cbpe_pkg::*;

  logic [PACK_W-1:0] start_point_r, first_control_r, second_control_r, end_point_r;
  logic [SEG_W-1:0]  num_segments_r;
  logic [SEG_W-1:0]  num_seg;
  cbpe_pts_t         pts;

  cbpe_tag_t         in_tag, div_tag, basis_tag;
  logic [T_W-1:0]    div_t;
  logic              div_ready, basis_ready;
  cbpe_wts_t         basis_w;
  logic              out_bad;
  cbpe_point_t       out_point;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_point_r    <= START_POINT_RST;
      first_control_r  <= FIRST_CONTROL_RST;
      second_control_r <= SECOND_CONTROL_RST;
      end_point_r      <= END_POINT_RST;
      num_segments_r   <= NUM_SEGMENTS_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_START_POINT:    start_point_r    <= cfg_wdata;
        REG_FIRST_CONTROL:  first_control_r  <= cfg_wdata;
        REG_SECOND_CONTROL: second_control_r <= cfg_wdata;
        REG_END_POINT:      end_point_r      <= cfg_wdata;
        REG_NUM_SEGMENTS:   num_segments_r   <= cfg_wdata[SEG_W-1:0];
        default: ;
      endcase
    end
  end

  // A segment count above the supported maximum is treated as the maximum.
  assign num_seg = (num_segments_r > SEG_W'(MAX_SEGMENTS)) ? SEG_W'(MAX_SEGMENTS)
                                                           : num_segments_r;
  assign pts     = {end_point_r, second_control_r, first_control_r, start_point_r};

  assign in_tag.valid = in_tvalid;
  assign in_tag.bad   = 1'b0;

  cbpe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_tag   (in_tag),
    .up_index (in_tdata[IDX_W-1:0]),
    .up_ready (in_tready),
    .num_seg  (num_seg),
    .dn_tag   (div_tag),
    .dn_t     (div_t),
    .dn_ready (div_ready)
  );

  cbpe_basis u_basis (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_tag   (div_tag),
    .up_t     (div_t),
    .up_ready (div_ready),
    .dn_tag   (basis_tag),
    .dn_w     (basis_w),
    .dn_ready (basis_ready)
  );

  cbpe_blend u_blend (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_tag   (basis_tag),
    .up_w     (basis_w),
    .up_ready (basis_ready),
    .pts      (pts),
    .dn_valid (out_tvalid),
    .dn_bad   (out_bad),
    .dn_point (out_point),
    .dn_ready (out_tready)
  );

  assign out_tdata = {{(OUT_TDATA_W - OUT_FIELD_W){1'b0}}, out_bad,
                      out_point[2], out_point[1], out_point[0]};

endmodule
